// File: design/ric_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_pkg: shared types and constants for the rgba image compare block
// field widths, size limits, register indexes and the ratio check request
// ----------------------------------------------------------------------------
package ric_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned COUNT_W    = 25;
  localparam int unsigned PIXELS_W   = 25;
  localparam int unsigned PRODUCT_W  = FRAC_W + PIXELS_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned FRAC_SHIFT = 16;

  localparam logic [SIZE_W-1:0]  MAX_WIDTH  = 13'd4096;
  localparam logic [SIZE_W-1:0]  MAX_HEIGHT = 13'd4096;
  localparam logic [COUNT_W-1:0] BAD_LIMIT  = {COUNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_TOLERANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BAD_FRACTION  = 2'd3;

  typedef struct packed {
    logic                 last;
    logic [COUNT_W-1:0]   bad_total;
    logic [FRAC_W-1:0]    fraction;
    logic [PIXELS_W-1:0]  pixels;
  } ratio_req_t;

endpackage

// File: design/ric_delta.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_delta: largest channel difference of one pixel pair
// four absolute differences and a small max tree
// ----------------------------------------------------------------------------
module ric_delta import ric_pkg::*; (
  input  logic [CHAN_W-1:0] gold_red,
  input  logic [CHAN_W-1:0] gold_green,
  input  logic [CHAN_W-1:0] gold_blue,
  input  logic [CHAN_W-1:0] gold_alpha,
  input  logic [CHAN_W-1:0] test_red,
  input  logic [CHAN_W-1:0] test_green,
  input  logic [CHAN_W-1:0] test_blue,
  input  logic [CHAN_W-1:0] test_alpha,
  output logic [CHAN_W-1:0] delta
);

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [CHAN_W-1:0] d_red;
  logic [CHAN_W-1:0] d_green;
  logic [CHAN_W-1:0] d_blue;
  logic [CHAN_W-1:0] d_alpha;
  logic [CHAN_W-1:0] max_rg;
  logic [CHAN_W-1:0] max_ba;

  assign d_red   = abs_diff(gold_red, test_red);
  assign d_green = abs_diff(gold_green, test_green);
  assign d_blue  = abs_diff(gold_blue, test_blue);
  assign d_alpha = abs_diff(gold_alpha, test_alpha);

  assign max_rg = (d_red > d_green) ? d_red : d_green;
  assign max_ba = (d_blue > d_alpha) ? d_blue : d_alpha;
  assign delta  = (max_rg > max_ba) ? max_rg : max_ba;

endmodule

// File: design/ric_ratio_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_ratio_check: bad pixel fraction test on the last pixel
// ok when bad_total * 65536 <= fraction * pixels, exact
// ----------------------------------------------------------------------------
module ric_ratio_check import ric_pkg::*; (
  input  ratio_req_t req,
  output logic       image_ok
);

  logic [PRODUCT_W-1:0] limit;
  logic [PRODUCT_W-1:0] scaled_bad;

  assign limit      = {{PIXELS_W{1'b0}}, req.fraction} * {{FRAC_W{1'b0}}, req.pixels};
  assign scaled_bad = {{(PRODUCT_W-COUNT_W){1'b0}}, req.bad_total} << FRAC_SHIFT;
  assign image_ok   = req.last && (scaled_bad <= limit);

endmodule

// File: design/rgba_image_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_image_compare: golden versus test rgba image comparator
// pipeline: input register, statistics register, result register; one pixel
//   pair per cycle while out_ready does not stall the output
// the fraction multiply sits alone in the last stage, the size multiply and
//   statistics update in the middle stage
// reset: synchronous, clears pipeline valids, statistics and position, and
//   sets width 1, height 1, tolerance 0, fraction 0
// ----------------------------------------------------------------------------
module rgba_image_compare import ric_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel pair requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAN_W-1:0]     gold_red,
  input  logic [CHAN_W-1:0]     gold_green,
  input  logic [CHAN_W-1:0]     gold_blue,
  input  logic [CHAN_W-1:0]     gold_alpha,
  input  logic [CHAN_W-1:0]     test_red,
  input  logic [CHAN_W-1:0]     test_green,
  input  logic [CHAN_W-1:0]     test_blue,
  input  logic [CHAN_W-1:0]     test_alpha,
  // per pixel results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAN_W-1:0]     pixel_delta,
  output logic                  pixel_bad,
  output logic                  last_pixel,
  output logic                  image_ok,
  output logic [CHAN_W-1:0]     max_delta,
  output logic [COUNT_W-1:0]    bad_count,
  output logic                  found_bad,
  output logic [POS_W-1:0]      first_bad_x,
  output logic [POS_W-1:0]      first_bad_y
);

  // configuration registers
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [CHAN_W-1:0] channel_tolerance;
  logic [FRAC_W-1:0] max_bad_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= SIZE_W'(1);
      image_height      <= SIZE_W'(1);
      channel_tolerance <= '0;
      max_bad_fraction  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:       image_width       <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:      image_height      <= cfg_data[SIZE_W-1:0];
        REG_CHANNEL_TOLERANCE: channel_tolerance <= cfg_data[CHAN_W-1:0];
        REG_MAX_BAD_FRACTION:  max_bad_fraction  <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids and moves: a stage loads when empty or when it drains
  logic s1_valid;
  logic s2_valid;
  logic s3_move;
  logic s2_move;
  logic s1_move;

  assign s3_move  = !out_valid || out_ready;
  assign s2_move  = !s2_valid || s3_move;
  assign s1_move  = !s1_valid || s2_move;
  assign in_ready = s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_move) s1_valid  <= in_valid;
      if (s2_move) s2_valid  <= s1_valid;
      if (s3_move) out_valid <= s2_valid;
    end
  end

  // stage 1: input register
  logic [CHAN_W-1:0] s1_gold_red;
  logic [CHAN_W-1:0] s1_gold_green;
  logic [CHAN_W-1:0] s1_gold_blue;
  logic [CHAN_W-1:0] s1_gold_alpha;
  logic [CHAN_W-1:0] s1_test_red;
  logic [CHAN_W-1:0] s1_test_green;
  logic [CHAN_W-1:0] s1_test_blue;
  logic [CHAN_W-1:0] s1_test_alpha;

  always_ff @(posedge clk) begin
    if (s1_move && in_valid) begin
      s1_gold_red   <= gold_red;
      s1_gold_green <= gold_green;
      s1_gold_blue  <= gold_blue;
      s1_gold_alpha <= gold_alpha;
      s1_test_red   <= test_red;
      s1_test_green <= test_green;
      s1_test_blue  <= test_blue;
      s1_test_alpha <= test_alpha;
    end
  end

  // stage 1 logic: pixel delta and statistics update
  logic [CHAN_W-1:0] delta;

  ric_delta u_delta (
    .gold_red   (s1_gold_red),
    .gold_green (s1_gold_green),
    .gold_blue  (s1_gold_blue),
    .gold_alpha (s1_gold_alpha),
    .test_red   (s1_test_red),
    .test_green (s1_test_green),
    .test_blue  (s1_test_blue),
    .test_alpha (s1_test_alpha),
    .delta      (delta)
  );

  // running image state
  logic [POS_W-1:0]   column_count;
  logic [POS_W-1:0]   row_count;
  logic [COUNT_W-1:0] bad_total;
  logic [CHAN_W-1:0]  worst_seen;
  logic               have_first;
  logic [POS_W-1:0]   first_column;
  logic [POS_W-1:0]   first_row;

  logic [SIZE_W-1:0]   width_eff;
  logic [SIZE_W-1:0]   height_eff;
  logic [PIXELS_W-1:0] pixels;
  logic                bad;
  logic                row_end;
  logic                last;
  logic [COUNT_W-1:0]  bad_total_next;
  logic [CHAN_W-1:0]   worst_seen_next;
  logic                have_first_next;
  logic [POS_W-1:0]    first_column_next;
  logic [POS_W-1:0]    first_row_next;

  always_comb begin
    // zero reads as one, oversize reads as the limit
    if (image_width == '0)            width_eff = SIZE_W'(1);
    else if (image_width > MAX_WIDTH) width_eff = MAX_WIDTH;
    else                              width_eff = image_width;
    if (image_height == '0)             height_eff = SIZE_W'(1);
    else if (image_height > MAX_HEIGHT) height_eff = MAX_HEIGHT;
    else                                height_eff = image_height;
  end

  // product of two clamped sizes stays within 2^24
  assign pixels = PIXELS_W'(width_eff * height_eff);

  assign bad     = delta > channel_tolerance;
  // a pixel at or past the last column ends its row, same for rows
  assign row_end = {1'b0, column_count} >= (width_eff - SIZE_W'(1));
  assign last    = row_end && ({1'b0, row_count} >= (height_eff - SIZE_W'(1)));

  always_comb begin
    worst_seen_next   = (delta > worst_seen) ? delta : worst_seen;
    bad_total_next    = bad_total;
    have_first_next   = have_first;
    first_column_next = first_column;
    first_row_next    = first_row;
    if (bad) begin
      // count saturates instead of wrapping
      if (bad_total != BAD_LIMIT) bad_total_next = bad_total + COUNT_W'(1);
      if (!have_first) begin
        have_first_next   = 1'b1;
        first_column_next = column_count;
        first_row_next    = row_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      bad_total    <= '0;
      worst_seen   <= '0;
      have_first   <= 1'b0;
      first_column <= '0;
      first_row    <= '0;
    end else if (s2_move && s1_valid) begin
      if (last) begin
        // image done, next pixel opens a fresh image
        column_count <= '0;
        row_count    <= '0;
        bad_total    <= '0;
        worst_seen   <= '0;
        have_first   <= 1'b0;
        first_column <= '0;
        first_row    <= '0;
      end else begin
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + POS_W'(1);
        end else begin
          column_count <= column_count + POS_W'(1);
        end
        bad_total    <= bad_total_next;
        worst_seen   <= worst_seen_next;
        have_first   <= have_first_next;
        first_column <= first_column_next;
        first_row    <= first_row_next;
      end
    end
  end

  // stage 2: per pixel fields plus the ratio check request
  logic [CHAN_W-1:0]  s2_delta;
  logic               s2_bad;
  logic [CHAN_W-1:0]  s2_max_delta;
  logic               s2_found_bad;
  logic [POS_W-1:0]   s2_first_x;
  logic [POS_W-1:0]   s2_first_y;
  ratio_req_t         s2_req;

  always_ff @(posedge clk) begin
    if (s2_move && s1_valid) begin
      s2_delta            <= delta;
      s2_bad              <= bad;
      s2_max_delta        <= worst_seen_next;
      s2_found_bad        <= have_first_next;
      s2_first_x          <= first_column_next;
      s2_first_y          <= first_row_next;
      s2_req.last         <= last;
      s2_req.bad_total    <= bad_total_next;
      s2_req.fraction     <= max_bad_fraction;
      s2_req.pixels       <= pixels;
    end
  end

  // stage 2 logic: fraction times pixel count against scaled bad count
  logic ok;

  ric_ratio_check u_ratio (
    .req      (s2_req),
    .image_ok (ok)
  );

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (s3_move && s2_valid) begin
      pixel_delta <= s2_delta;
      pixel_bad   <= s2_bad;
      last_pixel  <= s2_req.last;
      image_ok    <= ok;
      max_delta   <= s2_max_delta;
      bad_count   <= s2_req.bad_total;
      found_bad   <= s2_found_bad;
      first_bad_x <= s2_first_x;
      first_bad_y <= s2_first_y;
    end
  end

endmodule

// File: tb/sv/rgba_image_compare_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_image_compare_tb: self-checking bench for the rgba image comparator
// pixel pair requests come from a queue and results are checked against an
// in-bench model of the per-pixel and per-image statistics, across directed
// corner cases and randomly configured image sizes, tolerances and fractions
// ----------------------------------------------------------------------------
module rgba_image_compare_tb;
  import ric_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned CALM_ITEMS     = 850;

  // one pixel pair, channel 0 red, 1 green, 2 blue, 3 alpha
  typedef struct packed {
    logic [3:0][CHAN_W-1:0] gold;
    logic [3:0][CHAN_W-1:0] test;
  } pixel_pair_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  delta;
    logic               bad;
    logic               last;
    logic               ok;
    logic [CHAN_W-1:0]  peak;
    logic [COUNT_W-1:0] bad_count;
    logic               found;
    logic [POS_W-1:0]   first_x;
    logic [POS_W-1:0]   first_y;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic        in_valid  = 1'b0;
  logic        in_ready;
  pixel_pair_t cur_pair  = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAN_W-1:0]     pixel_delta;
  logic                  pixel_bad;
  logic                  last_pixel;
  logic                  image_ok;
  logic [CHAN_W-1:0]     max_delta;
  logic [COUNT_W-1:0]    bad_count;
  logic                  found_bad;
  logic [POS_W-1:0]      first_bad_x;
  logic [POS_W-1:0]      first_bad_y;

  // pending pixel pair requests and results still owed by the block
  pixel_pair_t   pair_q[$];
  pixel_result_t owed_q[$];

  // idle control of the driver and the receiver
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  logic        calm_mode    = 1'b0;
  int unsigned in_gap       = 0;
  int unsigned out_gap      = 0;

  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;

  // mirror of the configuration registers
  logic [SIZE_W-1:0] cfg_width  = 13'd1;
  logic [SIZE_W-1:0] cfg_height = 13'd1;
  logic [CHAN_W-1:0] cfg_tol    = '0;
  logic [FRAC_W-1:0] cfg_frac   = '0;

  // running image statistics as the block should hold them
  logic [POS_W-1:0]   col_pos     = '0;
  logic [POS_W-1:0]   row_pos     = '0;
  logic [COUNT_W-1:0] bad_tally   = '0;
  logic [CHAN_W-1:0]  peak_delta  = '0;
  logic               first_found = 1'b0;
  logic [POS_W-1:0]   first_col   = '0;
  logic [POS_W-1:0]   first_row   = '0;

  rgba_image_compare u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .gold_red    (cur_pair.gold[0]),
    .gold_green  (cur_pair.gold[1]),
    .gold_blue   (cur_pair.gold[2]),
    .gold_alpha  (cur_pair.gold[3]),
    .test_red    (cur_pair.test[0]),
    .test_green  (cur_pair.test[1]),
    .test_blue   (cur_pair.test[2]),
    .test_alpha  (cur_pair.test[3]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_delta (pixel_delta),
    .pixel_bad   (pixel_bad),
    .last_pixel  (last_pixel),
    .image_ok    (image_ok),
    .max_delta   (max_delta),
    .bad_count   (bad_count),
    .found_bad   (found_bad),
    .first_bad_x (first_bad_x),
    .first_bad_y (first_bad_y)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // size register as the block uses it: zero means one, too large clamps
  function automatic int unsigned size_in_use(logic [SIZE_W-1:0] raw, int unsigned top);
    if (raw == 0) return 1;
    return (raw > top) ? top : raw;
  endfunction

  // expected result of one pixel pair, advancing the image statistics
  function automatic pixel_result_t compare_pixel(pixel_pair_t p);
    pixel_result_t    r;
    logic [CHAN_W-1:0] d;
    logic [CHAN_W-1:0] delta;
    int unsigned      w;
    int unsigned      h;
    logic             row_end;
    longint unsigned  lhs;
    longint unsigned  rhs;
    r = '0;
    delta = '0;
    for (int c = 0; c < 4; c++) begin
      d = (p.gold[c] > p.test[c]) ? p.gold[c] - p.test[c] : p.test[c] - p.gold[c];
      if (d > delta) delta = d;
    end
    r.delta = delta;
    r.bad   = delta > cfg_tol;
    if (delta > peak_delta) peak_delta = delta;
    if (r.bad) begin
      // count saturates rather than wrapping
      if (bad_tally != BAD_LIMIT) bad_tally = bad_tally + 1'b1;
      if (!first_found) begin
        first_found = 1'b1;
        first_col   = col_pos;
        first_row   = row_pos;
      end
    end
    w = size_in_use(cfg_width, MAX_WIDTH);
    h = size_in_use(cfg_height, MAX_HEIGHT);
    // a position at or past the end still ends the row or image
    row_end = col_pos >= w - 1;
    r.last  = row_end && (row_pos >= h - 1);
    if (r.last) begin
      lhs  = longint'(bad_tally) << FRAC_SHIFT;
      rhs  = longint'(cfg_frac) * longint'(w) * longint'(h);
      r.ok = lhs <= rhs;
    end
    r.peak      = peak_delta;
    r.bad_count = bad_tally;
    r.found     = first_found;
    r.first_x   = first_found ? first_col : '0;
    r.first_y   = first_found ? first_row : '0;
    if (r.last) begin
      col_pos     = '0;
      row_pos     = '0;
      bad_tally   = '0;
      peak_delta  = '0;
      first_found = 1'b0;
      first_col   = '0;
      first_row   = '0;
    end else if (row_end) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // request driver: holds valid and payload until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) owed_q.push_back(compare_pixel(cur_pair));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          // idle burst in progress
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pair_q.size() != 0) begin
          cur_pair <= pair_q.pop_front();
          in_valid <= 1'b1;
          if (!calm_mode && $urandom_range(0, 99) < in_idle_pct)
            in_gap <= $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $error("result with no request pending");
          error_count++;
        end else begin
          pixel_result_t want;
          want = owed_q.pop_front();
          check_field("pixel_delta", want.delta,     pixel_delta);
          check_field("pixel_bad",   want.bad,       pixel_bad);
          check_field("last_pixel",  want.last,      last_pixel);
          check_field("image_ok",    want.ok,        image_ok);
          check_field("max_delta",   want.peak,      max_delta);
          check_field("bad_count",   want.bad_count, bad_count);
          check_field("found_bad",   want.found,     found_bad);
          check_field("first_bad_x", want.first_x,   first_bad_x);
          check_field("first_bad_y", want.first_y,   first_bad_y);
        end
      end
      if (out_gap != 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm_mode && $urandom_range(0, 99) < out_idle_pct)
          out_gap <= $urandom_range(1, 7);
      end
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pixel_pair_t pix(logic [31:0] g, logic [31:0] t);
    pixel_pair_t p;
    p.gold = g;
    p.test = t;
    return p;
  endfunction

  // gold random over full range, test offset by up to spread per channel or, one time in eight, random
  function automatic pixel_pair_t random_pair(int unsigned spread);
    pixel_pair_t p;
    int          g;
    int          off;
    for (int c = 0; c < 4; c++) begin
      g   = $urandom_range(0, 255);
      off = $urandom_range(0, spread);
      p.gold[c] = CHAN_W'(g);
      if ($urandom_range(0, 7) == 0) p.test[c] = CHAN_W'($urandom_range(0, 255));
      else if ($urandom_range(0, 1) == 1)
        p.test[c] = CHAN_W'((g + off > 255) ? 255 : g + off);
      else p.test[c] = CHAN_W'((g < off) ? 0 : g - off);
    end
    return p;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return MAX_WIDTH;
      2:       return SIZE_W'($urandom_range(4097, 8191));
      3:       return SIZE_W'($urandom_range(1, 4096));
      default: return SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    // block is idle here, so the mirror can follow at once
    case (idx)
      REG_IMAGE_WIDTH:       cfg_width  = data[SIZE_W-1:0];
      REG_IMAGE_HEIGHT:      cfg_height = data[SIZE_W-1:0];
      REG_CHANNEL_TOLERANCE: cfg_tol    = data[CHAN_W-1:0];
      REG_MAX_BAD_FRACTION:  cfg_frac   = data[FRAC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                          logic [CFG_DATA_W-1:0] tol, logic [CFG_DATA_W-1:0] frac);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_CHANNEL_TOLERANCE, tol);
    write_reg(REG_MAX_BAD_FRACTION, frac);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // all queued requests sent and every owed result received
  task automatic wait_quiet();
    do @(negedge clk);
    while (pair_q.size() != 0 || in_valid || owed_q.size() != 0);
  endtask

  initial begin
    int unsigned      total;
    int unsigned      n;
    int unsigned      pixels;
    int unsigned      spread;
    logic [SIZE_W-1:0] wv;
    logic [SIZE_W-1:0] hv;
    logic [CHAN_W-1:0] tol_v;
    logic [FRAC_W-1:0] frac_v;
    total = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings, every pixel a whole image
    in_idle_pct  = 30;
    out_idle_pct = 30;
    @(negedge clk);
    pair_q.push_back(pix(32'h0000_0000, 32'h0000_0000));
    pair_q.push_back(pix(32'h0000_0000, 32'h0000_0001));
    pair_q.push_back(pix(32'hFFFF_FFFF, 32'h0000_0000));
    wait_quiet();

    // 3x2 image: tolerance edge, each channel as the largest one
    set_regs(17'd3, 17'd2, 17'd10, 17'd32768);
    @(negedge clk);
    pair_q.push_back(pix(32'h0000_0014, 32'h0000_000A));
    pair_q.push_back(pix(32'h0000_0B00, 32'h0000_0000));
    pair_q.push_back(pix(32'h00C8_0000, 32'h0000_0000));
    pair_q.push_back(pix(32'h0000_0000, 32'hFF00_0000));
    pair_q.push_back(pix(32'h1234_5678, 32'h1234_5678));
    pair_q.push_back(pix(32'hAA55_AA55, 32'h55AA_55AA));
    wait_quiet();

    // zero sizes act as one, fraction above one passes everything
    set_regs(17'd0, 17'd0, 17'd255, 17'h1FFFF);
    @(negedge clk);
    pair_q.push_back(pix(32'hFFFF_FFFF, 32'h0000_0000));
    wait_quiet();
    set_regs(17'd0, 17'd0, 17'd0, 17'h1FFFF);
    @(negedge clk);
    pair_q.push_back(pix(32'h0000_0000, 32'hFFFF_FFFF));
    wait_quiet();

    // oversize clamps to the maximum, then shrink mid-row
    set_regs(17'h1FFF, 17'd5000, 17'd128, 17'd65536);
    @(negedge clk);
    repeat (4) pair_q.push_back(random_pair(255));
    wait_quiet();
    set_regs(17'd2, 17'd2, 17'd128, 17'd65536);
    @(negedge clk);
    repeat (3) pair_q.push_back(random_pair(255));

    // random phases; image ends and size changes fall anywhere
    while (total < RANDOM_ITEMS) begin
      wait_quiet();
      if (total >= CALM_ITEMS) calm_mode = 1'b1;
      case ($urandom_range(0, 3))
        0: in_idle_pct = 0;
        1: in_idle_pct = 10;
        2: in_idle_pct = 30;
        default: in_idle_pct = 60;
      endcase
      case ($urandom_range(0, 3))
        0: out_idle_pct = 0;
        1: out_idle_pct = 10;
        2: out_idle_pct = 30;
        default: out_idle_pct = 60;
      endcase
      wv = pick_size();
      hv = pick_size();
      case ($urandom_range(0, 5))
        0:       tol_v = '0;
        1:       tol_v = 8'd255;
        2:       tol_v = CHAN_W'($urandom_range(0, 255));
        default: tol_v = CHAN_W'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 5))
        0:       frac_v = '0;
        1:       frac_v = 17'd65536;
        2:       frac_v = FRAC_W'($urandom_range(65537, 131071));
        default: frac_v = FRAC_W'($urandom_range(0, 65536));
      endcase
      // unused upper data bits carry junk the block must drop
      set_regs({4'($urandom), wv}, {4'($urandom), hv}, {9'($urandom), tol_v}, frac_v);
      pixels = size_in_use(wv, MAX_WIDTH) * size_in_use(hv, MAX_HEIGHT);
      n = (pixels <= 64) ? $urandom_range(1, 2 * pixels + 8) : $urandom_range(1, 40);
      spread = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
      @(negedge clk);
      repeat (n) pair_q.push_back(random_pair(spread));
      total += n;
    end

    wait_quiet();
    // let the clock run on to catch any stray result
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
